### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define CPAB_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define CPAB_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPAB_AST_IMP(lbl, ante, cons, msg)
`define CPAB_AST_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/cpab_pkg.sv
// types, constants and helper functions for the canvas alpha blend writer
package cpab_pkg;

    localparam int CANVAS_SIDE  = 32;
    localparam int CANVAS_DEPTH = CANVAS_SIDE * CANVAS_SIDE;
    localparam int IDX_W        = $clog2(CANVAS_DEPTH);
    localparam int COORD_W      = 5;
    localparam int CH_W         = 8;
    localparam int PIX_W        = 4 * CH_W;
    localparam int PROD_W       = 2 * CH_W;
    localparam int NUM_CH       = 3;

    localparam logic [CH_W-1:0] CH_MAX = '1;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [CH_W-1:0]    brush_red;
        logic [CH_W-1:0]    brush_green;
        logic [CH_W-1:0]    brush_blue;
        logic [CH_W-1:0]    brush_alpha;
    } t_pix_item;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            was_blended;
    } t_res_item;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [CH_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] quot;
    } t_div_rsp;

    // exact floor(x / 255) for any 16-bit x whose quotient fits in 8 bits
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] xp1;
        logic [PROD_W:0] acc;
        begin
            xp1 = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1};
            acc = xp1 + (xp1 >> CH_W);
            div255 = acc[PROD_W-1:CH_W];
        end
    endfunction

endpackage

### rtl/cpab_if.sv
// valid/ready channels for pixel items and result items
interface cpab_pix_if;
    logic                 valid;
    logic                 ready;
    cpab_pkg::t_pix_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpab_res_if;
    logic                 valid;
    logic                 ready;
    cpab_pkg::t_res_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/cpab_ram.sv
// generic single-port-write, single-port-read ram with registered read
module cpab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cpab_div.sv
// iterative 16/8 divider, two quotient bits a cycle, saturating at 255
`include "assert_macros.svh"

module cpab_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpab_pkg::t_div_req  i_req,
    output cpab_pkg::t_div_rsp  o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [1:0]                 r_cnt;
    logic                       r_sat;
    logic [cpab_pkg::CH_W-1:0]  r_rem;
    logic [cpab_pkg::CH_W-1:0]  r_lo;
    logic [cpab_pkg::CH_W-1:0]  r_den;

    logic [cpab_pkg::CH_W:0]    rem_a;
    logic [cpab_pkg::CH_W:0]    rem_b;
    logic [cpab_pkg::CH_W:0]    den9;
    logic                       q_a;
    logic                       q_b;
    logic [cpab_pkg::CH_W-1:0]  n_rem_a;
    logic [cpab_pkg::CH_W-1:0]  n_rem_b;
    logic [cpab_pkg::CH_W-1:0]  num_hi;
    logic [cpab_pkg::CH_W-1:0]  num_lo;

    assign num_hi = i_req.num[cpab_pkg::PROD_W-1:cpab_pkg::CH_W];
    assign num_lo = i_req.num[cpab_pkg::CH_W-1:0];
    assign den9   = {1'b0, r_den};

    // two restoring steps; remainder stays below the divisor unless the quotient saturates
    always_comb begin
        rem_a   = {r_rem, r_lo[cpab_pkg::CH_W-1]};
        q_a     = (rem_a >= den9);
        n_rem_a = q_a ? 8'(rem_a - den9) : rem_a[cpab_pkg::CH_W-1:0];
        rem_b   = {n_rem_a, r_lo[cpab_pkg::CH_W-2]};
        q_b     = (rem_b >= den9);
        n_rem_b = q_b ? 8'(rem_b - den9) : rem_b[cpab_pkg::CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // quotient of 256 or more when the high byte reaches the divisor
            r_sat <= (num_hi >= i_req.den);
            r_rem <= num_hi;
            r_lo  <= num_lo;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem_b;
            r_lo  <= {r_lo[cpab_pkg::CH_W-3:0], q_a, q_b};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? cpab_pkg::CH_MAX : r_lo;

    `CPAB_AST_NXT(a_done_pulse, r_done, !r_done, "divider done held longer than one cycle")
    `CPAB_AST_IMP(a_start_idle, i_req.start, !r_busy, "divider started while busy")
    `CPAB_AST_NXT(a_start_busy, i_req.start, r_busy && !r_done, "divider did not begin after start")

endmodule

### rtl/canvas_pixel_alpha_blend_write.sv
// Canvas pixel painter: read pixel, blend brush "over" it, write back and report.
// An item goes from IDLE through MUL, ALPHA, PROD and NUM, then DSTART and DWAIT per colour
// when blended, or straight to WRITE when copied or zero alpha; WRITE waits for a free output.
// One item at a time. Blended items use the single divider for each of three colours in turn.
// After reset the canvas is zeroed one pixel a cycle (all 1024 pixels), no item taken then.
`include "assert_macros.svh"

module canvas_pixel_alpha_blend_write (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpab_pix_if.sink          i_pix,
    cpab_res_if.source        o_res
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_ALPHA  = 4'd3;
    localparam logic [3:0] ST_PROD   = 4'd4;
    localparam logic [3:0] ST_NUM    = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DWAIT  = 4'd7;
    localparam logic [3:0] ST_WRITE  = 4'd8;

    localparam int CH_W   = cpab_pkg::CH_W;
    localparam int PROD_W = cpab_pkg::PROD_W;
    localparam int IDX_W  = cpab_pkg::IDX_W;
    localparam int NUM_CH = cpab_pkg::NUM_CH;

    logic [3:0]              r_state;
    logic [IDX_W-1:0]        r_clr_addr;
    logic [1:0]              r_ch;
    logic                    r_out_valid;
    cpab_pkg::t_res_item     r_out;

    cpab_pkg::t_pix_item     r_item;
    logic                    r_inside;
    logic [IDX_W-1:0]        r_idx;
    logic [cpab_pkg::PIX_W-1:0] r_dst;
    logic                    r_zero;
    logic [PROD_W-1:0]       r_p;
    logic [CH_W-1:0]         r_t;
    logic [CH_W-1:0]         r_rem;
    logic [CH_W-1:0]         r_oa;
    logic [PROD_W-1:0]       r_sprod [NUM_CH];
    logic [PROD_W-1:0]       r_tprod [NUM_CH];
    logic [PROD_W-1:0]       r_rprod [NUM_CH];
    logic [PROD_W-1:0]       r_num   [NUM_CH];
    logic [CH_W-1:0]         r_q     [NUM_CH];

    logic [3:0]              n_state;
    logic                    acc;
    logic                    inside_in;
    logic [IDX_W-1:0]        idx_in;
    logic                    out_free;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [cpab_pkg::PIX_W-1:0] ram_wdata;
    logic [cpab_pkg::PIX_W-1:0] ram_rdata;
    logic [cpab_pkg::PIX_W-1:0] dst_in;
    logic [CH_W-1:0]         src_c [NUM_CH];
    logic [CH_W-1:0]         dst_c [NUM_CH];
    logic [CH_W-1:0]         res_c [NUM_CH];
    logic [CH_W-1:0]         t_in;
    logic [PROD_W-1:0]       rem_w;
    logic [CH_W:0]           oa_sum;
    logic [PROD_W:0]         num_sum [NUM_CH];
    cpab_pkg::t_res_item     res_item;
    cpab_pkg::t_div_req      div_req;
    cpab_pkg::t_div_rsp      div_rsp;

    assign acc         = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;

    assign inside_in = (32'(i_pix.data.pix_x) < cpab_pkg::CANVAS_SIDE) &&
                       (32'(i_pix.data.pix_y) < cpab_pkg::CANVAS_SIDE);
    assign idx_in    = IDX_W'(32'(i_pix.data.pix_y) * cpab_pkg::CANVAS_SIDE +
                              32'(i_pix.data.pix_x));

    // pixels outside the canvas read as empty
    assign dst_in = r_inside ? ram_rdata : '0;

    always_comb begin
        src_c[0] = r_item.brush_red;
        src_c[1] = r_item.brush_green;
        src_c[2] = r_item.brush_blue;
        for (int c = 0; c < NUM_CH; c++) begin
            dst_c[c] = r_dst[c*CH_W +: CH_W];
        end
    end

    // alpha: t = ad*(255-as)/255 split into quotient and remainder
    assign t_in   = cpab_pkg::div255(r_p);
    assign rem_w  = r_p - ((PROD_W'(t_in) << CH_W) - PROD_W'(t_in));
    assign oa_sum = {1'b0, r_item.brush_alpha} + {1'b0, t_in};

    // cd*ad*(255-as)/255 = cd*t + floor(cd*rem/255)
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            num_sum[c] = {1'b0, r_sprod[c]} + {1'b0, r_tprod[c]} +
                         {{(PROD_W-CH_W+1){1'b0}}, cpab_pkg::div255(r_rprod[c])};
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_zero) begin
                res_c[c] = src_c[c];
            end else if (r_oa == '0) begin
                res_c[c] = '0;
            end else begin
                res_c[c] = r_q[c];
            end
        end
        res_item.out_red     = res_c[0];
        res_item.out_green   = res_c[1];
        res_item.out_blue    = res_c[2];
        res_item.out_alpha   = r_zero ? r_item.brush_alpha : r_oa;
        res_item.was_blended = !r_zero;
    end

    assign div_req.start = (r_state == ST_DSTART);
    assign div_req.num   = r_num[r_ch];
    assign div_req.den   = r_oa;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(cpab_pkg::CANVAS_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_ALPHA;
            ST_ALPHA: n_state = ST_PROD;
            ST_PROD:  n_state = ST_NUM;
            ST_NUM: begin
                n_state = (r_zero || r_oa == '0) ? ST_WRITE : ST_DSTART;
            end
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_ch == 2'(NUM_CH - 1)) ? ST_WRITE : ST_DSTART;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (r_state == ST_NUM) begin
                r_ch <= '0;
            end else if (r_state == ST_DWAIT && div_rsp.done) begin
                r_ch <= r_ch + 2'd1;
            end
            if (r_state == ST_WRITE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item   <= i_pix.data;
            r_inside <= inside_in;
            r_idx    <= idx_in;
        end
        if (r_state == ST_MUL) begin
            r_dst  <= dst_in;
            r_zero <= (dst_in == '0);
            r_p    <= PROD_W'(dst_in[3*CH_W +: CH_W]) *
                      PROD_W'(cpab_pkg::CH_MAX - r_item.brush_alpha);
        end
        if (r_state == ST_ALPHA) begin
            r_t   <= t_in;
            r_rem <= rem_w[CH_W-1:0];
            r_oa  <= oa_sum[CH_W-1:0];
        end
        if (r_state == ST_PROD) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_sprod[c] <= PROD_W'(src_c[c]) * PROD_W'(r_item.brush_alpha);
                r_tprod[c] <= PROD_W'(dst_c[c]) * PROD_W'(r_t);
                r_rprod[c] <= PROD_W'(dst_c[c]) * PROD_W'(r_rem);
            end
        end
        if (r_state == ST_NUM) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_num[c] <= num_sum[c][PROD_W-1:0];
            end
        end
        if (r_state == ST_DWAIT && div_rsp.done) begin
            r_q[r_ch] <= div_rsp.quot;
        end
        if (r_state == ST_WRITE && out_free) begin
            r_out <= res_item;
        end
    end

    assign ram_we    = (r_state == ST_CLEAR) ||
                       (r_state == ST_WRITE && out_free && r_inside);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 :
                       {res_item.out_alpha, res_item.out_blue,
                        res_item.out_green, res_item.out_red};

    cpab_ram #(
        .WIDTH (cpab_pkg::PIX_W),
        .DEPTH (cpab_pkg::CANVAS_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (acc),
        .i_raddr (idx_in),
        .o_rdata (ram_rdata)
    );

    cpab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    `CPAB_AST_NXT(a_acc_read, acc, r_state == ST_MUL, "accepted item did not start the read")
    `CPAB_AST_IMP(a_div_lane, div_rsp.done, r_state == ST_DWAIT, "divider result outside a wait")
    `CPAB_AST_NXT(a_wb_out, ram_we && r_state == ST_WRITE, r_out_valid, "write-back without result")
    `CPAB_AST_IMP(a_clear_no_acc, r_state == ST_CLEAR, !i_pix.ready, "item taken during clear")

endmodule

### verif/cpab_blend_checker.sv
// result checker for the canvas alpha blend writer: shadow canvas, blend prediction, compare
`timescale 1ns / 100ps

module cpab_blend_checker
    import cpab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpab_pix_if        i_pix_mon,
    cpab_res_if        i_res_mon,
    output int         o_err_cnt,
    output int         o_checked_cnt,
    output int         o_left_cnt
);

    localparam int unsigned CH_FULL = CH_MAX;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_rgba;

    t_rgba      canvas_img [CANVAS_DEPTH];
    t_res_item  painted_q [$];
    int         err_cnt = 0;
    int         checked_cnt = 0;

    assign o_err_cnt = err_cnt;

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t cpab check: %s got %0d want %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // one colour channel of the over blend, saturated to 8 bits
    function automatic logic [CH_W-1:0] mix_channel(input int unsigned cs, input int unsigned cd,
                                                    input int unsigned sa, input int unsigned da,
                                                    input int unsigned oa);
        int unsigned num;
        int unsigned q;
        num = cs * sa + (cd * da * (CH_FULL - sa)) / CH_FULL;
        q   = num / oa;
        return (q > CH_FULL) ? CH_MAX : q[CH_W-1:0];
    endfunction

    // paints one brush item onto the shadow canvas and returns what gets written
    function automatic t_res_item paint_pixel(input t_pix_item it);
        bit          on_canvas;
        int unsigned idx;
        int unsigned sa;
        int unsigned da;
        int unsigned oa;
        t_rgba       dst;
        t_res_item   res;
        on_canvas = (32'(it.pix_x) < CANVAS_SIDE) && (32'(it.pix_y) < CANVAS_SIDE);
        idx = on_canvas ? (32'(it.pix_y) * CANVAS_SIDE + 32'(it.pix_x)) : 0;
        dst = on_canvas ? canvas_img[idx] : '0;
        res = '0;
        if (dst == '0) begin
            res.out_red     = it.brush_red;
            res.out_green   = it.brush_green;
            res.out_blue    = it.brush_blue;
            res.out_alpha   = it.brush_alpha;
            res.was_blended = 1'b0;
        end else begin
            sa = 32'(it.brush_alpha);
            da = 32'(dst.alpha);
            oa = sa + (da * (CH_FULL - sa)) / CH_FULL;
            res.out_alpha   = oa[CH_W-1:0];
            res.was_blended = 1'b1;
            // zero blended alpha leaves the colours at zero
            if (oa != 0) begin
                res.out_red   = mix_channel(32'(it.brush_red), 32'(dst.red), sa, da, oa);
                res.out_green = mix_channel(32'(it.brush_green), 32'(dst.green), sa, da, oa);
                res.out_blue  = mix_channel(32'(it.brush_blue), 32'(dst.blue), sa, da, oa);
            end
        end
        if (on_canvas) begin
            canvas_img[idx] = '{red: res.out_red, green: res.out_green,
                                blue: res.out_blue, alpha: res.out_alpha};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_res_item want;
        t_res_item got;
        t_res_item painted;
        if (!i_rst_n) begin
            for (int k = 0; k < CANVAS_DEPTH; k++) begin
                canvas_img[k] = '0;
            end
            painted_q.delete();
        end else begin
            // results first, so an item accepted at this edge is never matched here
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = i_res_mon.data;
                if (painted_q.size() == 0) begin
                    note_mismatch("unexpected result, alpha", 32'(got.out_alpha), 0);
                end else begin
                    want = painted_q.pop_front();
                    if (got.out_red !== want.out_red)
                        note_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
                    if (got.out_green !== want.out_green)
                        note_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
                    if (got.out_blue !== want.out_blue)
                        note_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
                    if (got.out_alpha !== want.out_alpha)
                        note_mismatch("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
                    if (got.was_blended !== want.was_blended)
                        note_mismatch("was_blended", 32'(got.was_blended),
                                      32'(want.was_blended));
                end
                checked_cnt++;
            end
            if (i_pix_mon.valid && i_pix_mon.ready) begin
                painted   = paint_pixel(i_pix_mon.data);
                painted_q = {painted_q, painted};
            end
        end
        o_checked_cnt <= checked_cnt;
        o_left_cnt    <= painted_q.size();
    end

endmodule

### verif/canvas_pixel_alpha_blend_write_tb.sv
// testbench top for the canvas alpha blend writer: clock, reset, brush stimulus, verdict
`timescale 1ns / 100ps

module canvas_pixel_alpha_blend_write_tb;
    import cpab_pkg::*;

    localparam int RAND_ITEMS  = 900;
    localparam int CALM_ITEMS  = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpab_pix_if pix_ch ();
    cpab_res_if res_ch ();

    int  chk_errs;
    int  chk_done;
    int  chk_left;
    int  n_sent = 0;
    int  cyc_cnt = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    canvas_pixel_alpha_blend_write dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    cpab_blend_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_mon     (pix_ch),
        .i_res_mon     (res_ch),
        .o_err_cnt     (chk_errs),
        .o_checked_cnt (chk_done),
        .o_left_cnt    (chk_left)
    );

    function automatic t_pix_item brush(input int x, input int y, input int r, input int g,
                                        input int b, input int a);
        t_pix_item it;
        it.pix_x       = COORD_W'(x);
        it.pix_y       = COORD_W'(y);
        it.brush_red   = CH_W'(r);
        it.brush_green = CH_W'(g);
        it.brush_blue  = CH_W'(b);
        it.brush_alpha = CH_W'(a);
        return it;
    endfunction

    function automatic int pick_colour();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // mostly a small hot region so strokes land on painted pixels and blend
    function automatic t_pix_item rand_stroke();
        int x;
        int y;
        int a;
        case ($urandom_range(0, 9))
            0, 1: begin
                x = $urandom_range(0, 31);
                y = $urandom_range(0, 31);
            end
            2, 3: begin
                x = $urandom_range(0, 7);
                y = $urandom_range(0, 7);
            end
            default: begin
                x = $urandom_range(0, 3);
                y = $urandom_range(0, 3);
            end
        endcase
        // alpha leans on the edges: transparent, faint, nearly and fully opaque
        case ($urandom_range(0, 7))
            0:       a = 0;
            1:       a = $urandom_range(1, 3);
            2:       a = 255;
            3:       a = $urandom_range(252, 254);
            default: a = $urandom_range(0, 255);
        endcase
        return brush(x, y, pick_colour(), pick_colour(), pick_colour(), a);
    endfunction

    // valid stays high from one item to the next unless a gap is taken
    task automatic offer_item(input t_pix_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("canvas_pixel_alpha_blend_write_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // transparent copy leaves colour with zero alpha, then zero blended alpha clears it
        offer_item(brush(0, 0, 10, 20, 30, 0));
        offer_item(brush(0, 0, 1, 2, 3, 0));
        offer_item(brush(0, 0, 255, 255, 255, 255));
        offer_item(brush(0, 0, 0, 0, 0, 0));
        offer_item(brush(0, 0, 0, 0, 0, 255));
        // faint white over faint white overflows the colour channels
        offer_item(brush(31, 31, 255, 255, 255, 1));
        offer_item(brush(31, 31, 255, 255, 255, 1));
        offer_item(brush(31, 0, 0, 0, 0, 0));
        offer_item(brush(31, 0, 255, 0, 255, 128));
        offer_item(brush(31, 0, 0, 255, 0, 128));
        offer_item(brush(0, 31, 255, 255, 255, 255));
        offer_item(brush(0, 31, 255, 255, 255, 255));
        offer_item(brush(21, 10, 170, 85, 170, 85));
        offer_item(brush(21, 10, 85, 170, 85, 170));
        offer_item(brush(10, 21, 85, 170, 85, 170));
        offer_item(brush(10, 21, 255, 0, 0, 254));
        offer_item(brush(10, 21, 0, 0, 255, 1));

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 300) hold_req = 1'b1;
            if (i >= RAND_ITEMS - CALM_ITEMS) begin
                idle_on = 1'b0;
            end else if (i % 150 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            offer_item(rand_stroke());
        end
        pix_ch.valid <= 1'b0;

        while (chk_done < n_sent) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (chk_errs == 0 && chk_left == 0) begin
            $display("canvas_pixel_alpha_blend_write_tb: done, clean");
        end else begin
            $display("canvas_pixel_alpha_blend_write_tb: done, errors");
        end
        $finish;
    end

endmodule
